>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion wrappers, empty when SYNTH is defined
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_PROP(lbl, clk, rst_n, prop, msg)

`define ASSERT_NEVER(lbl, clk, rst_n, expr, msg)

`endif

`endif

>>> rtl/bfe_pkg.sv
// ---------------------------------------------------------------------------
// bfe_pkg
// shared types, constants and frame encoding functions
// ---------------------------------------------------------------------------
package bfe_pkg;

  localparam int NUM_BYTES   = 6;
  localparam int CRC_BYTES   = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [16:0] ID_MODULE_BASE = 17'h06000;
  localparam logic [16:0] ID_PACK1       = 17'h08000;
  localparam logic [16:0] ID_PACK2       = 17'h08010;
  localparam logic [16:0] ID_PACK3       = 17'h08020;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0]  FILL_BYTE      = 8'hFF;
  localparam logic [7:0]  TYPE_BALANCE   = 8'h01;
  localparam logic [7:0]  TYPE_VOLT_BASE = 8'h02;
  localparam logic [7:0]  TYPE_TEMP_TOP  = 8'h0F;
  localparam logic [5:0]  VOLT_HI_MASK   = 6'h3F;
  localparam logic signed [16:0] TEMP_OFFSET = 17'sd40;
  localparam logic signed [16:0] TEMP_MAX    = 17'sd255;

  // group / 12 as (group * 171) >> 11, exact for 8-bit group
  localparam logic [15:0] DIV12_RECIP = 16'd171;
  localparam int          DIV12_SHIFT = 11;
  localparam logic [7:0]  GROUP_SIZE  = 8'd12;

  typedef enum logic [2:0] {
    CMD_BALANCE    = 3'd0,
    CMD_CELL_VOLTS = 3'd1,
    CMD_TEMPS      = 3'd2,
    CMD_PACK1      = 3'd3,
    CMD_PACK2      = 3'd4,
    CMD_PACK3      = 3'd5
  } bfe_cmd_t;

  typedef struct packed {
    logic [16:0]                frame_id;
    logic [NUM_BYTES-1:0][7:0]  bytes;
  } bfe_item_t;

  typedef struct packed {
    logic ready;
    logic valid;
  } bfe_qstat_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {data, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic logic [7:0] temp_code(input logic [15:0] v);
    logic signed [16:0] t;
    t = signed'({v[15], v}) + TEMP_OFFSET;
    if (t < 0) begin
      return 8'h00;
    end else if (t > TEMP_MAX) begin
      return 8'hFF;
    end else begin
      return t[7:0];
    end
  endfunction

  function automatic logic [7:0] volt_hi(input logic [15:0] v);
    return {2'b00, v[13:8] & VOLT_HI_MASK};
  endfunction

  function automatic logic [16:0] module_frame_id(input logic [7:0] module_id,
                                                  input logic [7:0] frame_type);
    logic [7:0] m;
    m = module_id + 8'd1;
    return ID_MODULE_BASE + {1'b0, m, 8'h00} + {9'h000, frame_type};
  endfunction

endpackage

>>> rtl/battery_frame_encoder_crc16_core.sv
// ---------------------------------------------------------------------------
// battery_frame_encoder_crc16_core
// battery-monitor bus frame builder with crc-16 over the frame head
// ---------------------------------------------------------------------------
// A request is taken on any edge with start high and busy low, one per clock.
// Commands 0 to 5 each give exactly one result, marked by out_valid for one
// cycle. It passes through the frame builder register, the hand-off queue
// and the crc pipeline, which folds in one payload byte per stage. Commands
// 6 and 7 give no result. The receiver cannot stall, so the queue always
// drains and busy stays low in normal use.
`include "assert_macros.svh"

module battery_frame_encoder_crc16_core import bfe_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_module_id,
  input  logic [7:0]  in_group,
  input  logic [15:0] in_value_0,
  input  logic [15:0] in_value_1,
  input  logic [15:0] in_value_2,
  input  logic [15:0] in_value_3,
  input  logic [15:0] in_value_4,
  input  logic [15:0] in_value_5,
  output logic        out_valid,
  output logic [16:0] out_frame_id,
  output logic [7:0]  out_byte_0,
  output logic [7:0]  out_byte_1,
  output logic [7:0]  out_byte_2,
  output logic [7:0]  out_byte_3,
  output logic [7:0]  out_byte_4,
  output logic [7:0]  out_byte_5,
  output logic [7:0]  out_crc_high,
  output logic [7:0]  out_crc_low
);

  bfe_qstat_t  q_stat;
  logic        push;
  bfe_item_t   push_item;
  logic        pop;
  bfe_item_t   pop_item;
  logic        front_vld;
  bfe_item_t   res_item;
  logic [15:0] res_crc;

  bfe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .command   (in_command),
    .module_id (in_module_id),
    .group     (in_group),
    .value_0   (in_value_0),
    .value_1   (in_value_1),
    .value_2   (in_value_2),
    .value_3   (in_value_3),
    .value_4   (in_value_4),
    .value_5   (in_value_5),
    .q_stat    (q_stat),
    .push      (push),
    .push_item (push_item),
    .front_vld (front_vld)
  );

  bfe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  bfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .res_valid (out_valid),
    .res_item  (res_item),
    .res_crc   (res_crc)
  );

  assign out_frame_id = res_item.frame_id;
  assign out_byte_0   = res_item.bytes[0];
  assign out_byte_1   = res_item.bytes[1];
  assign out_byte_2   = res_item.bytes[2];
  assign out_byte_3   = res_item.bytes[3];
  assign out_byte_4   = res_item.bytes[4];
  assign out_byte_5   = res_item.bytes[5];
  assign out_crc_high = res_crc[15:8];
  assign out_crc_low  = res_crc[7:0];

  `ASSERT_PROP(a_unused_cmd_dropped, clk, rst_n, (start && !busy && in_command > CMD_PACK3) |=> !front_vld, "unused command reached the queue")
  `ASSERT_PROP(a_valid_cmd_kept, clk, rst_n, (start && !busy && in_command <= CMD_PACK3) |=> front_vld, "valid command was lost")
  `ASSERT_NEVER(a_busy_without_item, clk, rst_n, busy && !front_vld, "busy with empty front stage")

endmodule

>>> rtl/bfe_front.sv
// ---------------------------------------------------------------------------
// bfe_front
// takes requests, drops unused commands, builds identifier and payload bytes
// ---------------------------------------------------------------------------
module bfe_front import bfe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [7:0]  module_id,
  input  logic [7:0]  group,
  input  logic [15:0] value_0,
  input  logic [15:0] value_1,
  input  logic [15:0] value_2,
  input  logic [15:0] value_3,
  input  logic [15:0] value_4,
  input  logic [15:0] value_5,
  input  bfe_qstat_t  q_stat,
  output logic        push,
  output bfe_item_t   push_item,
  output logic        front_vld
);

  logic        fr_vld_r, fr_vld_nxt;
  bfe_item_t   fr_item_r, fr_item_nxt;
  bfe_item_t   built;
  logic        cmd_ok;
  logic        accept;
  logic [15:0] div_prod;
  logic [4:0]  grp_quot;
  logic [7:0]  grp_rem;
  logic [7:0]  volt_type;

  assign div_prod  = {8'h00, group} * DIV12_RECIP;
  assign grp_quot  = div_prod[DIV12_SHIFT +: 5];
  assign grp_rem   = group - ({3'b000, grp_quot} * GROUP_SIZE);
  assign volt_type = {grp_quot[3:0], 4'h0} + TYPE_VOLT_BASE + grp_rem;

  always_comb begin
    built  = '0;
    cmd_ok = 1'b1;
    case (bfe_cmd_t'(command))
      CMD_BALANCE: begin
        built.frame_id = module_frame_id(module_id, TYPE_BALANCE);
        built.bytes[0] = FILL_BYTE;
        built.bytes[1] = FILL_BYTE;
        built.bytes[2] = value_0[15:8];
        built.bytes[3] = value_0[7:0];
        built.bytes[4] = value_1[15:8];
        built.bytes[5] = value_1[7:0];
      end
      CMD_CELL_VOLTS: begin
        built.frame_id = module_frame_id(module_id, volt_type);
        built.bytes[0] = value_0[7:0];
        built.bytes[1] = volt_hi(value_0);
        built.bytes[2] = value_1[7:0];
        built.bytes[3] = volt_hi(value_1);
        built.bytes[4] = value_2[7:0];
        built.bytes[5] = volt_hi(value_2);
      end
      CMD_TEMPS: begin
        built.frame_id = module_frame_id(module_id, TYPE_TEMP_TOP - group);
        built.bytes[0] = temp_code(value_0);
        built.bytes[1] = temp_code(value_1);
        built.bytes[2] = temp_code(value_2);
        built.bytes[3] = temp_code(value_3);
        built.bytes[4] = temp_code(value_4);
        built.bytes[5] = temp_code(value_5);
      end
      CMD_PACK1: begin
        built.frame_id = ID_PACK1;
        built.bytes[0] = value_0[15:8];
        built.bytes[1] = value_0[7:0];
        built.bytes[2] = value_1[7:0];
        built.bytes[3] = volt_hi(value_1);
        built.bytes[4] = value_2[7:0];
        built.bytes[5] = volt_hi(value_2);
      end
      CMD_PACK2: begin
        built.frame_id = ID_PACK2;
        built.bytes[0] = value_0[7:0];
        built.bytes[1] = volt_hi(value_0);
        built.bytes[2] = value_1[15:8];
        built.bytes[3] = value_1[7:0];
        built.bytes[4] = value_2[15:8];
        built.bytes[5] = value_2[7:0];
      end
      CMD_PACK3: begin
        built.frame_id = ID_PACK3;
        built.bytes[0] = temp_code(value_0);
        built.bytes[1] = temp_code(value_1);
        built.bytes[2] = temp_code(value_2);
        built.bytes[3] = FILL_BYTE;
        built.bytes[4] = FILL_BYTE;
        built.bytes[5] = FILL_BYTE;
      end
      default: begin
        cmd_ok = 1'b0;
      end
    endcase
  end

  assign busy   = fr_vld_r && !q_stat.ready;
  assign accept = start && !busy;

  always_comb begin
    fr_vld_nxt  = fr_vld_r;
    fr_item_nxt = fr_item_r;
    if (accept) begin
      fr_vld_nxt  = cmd_ok;
      fr_item_nxt = built;
    end else if (q_stat.ready) begin
      fr_vld_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fr_vld_r <= 1'b0;
    end else begin
      fr_vld_r <= fr_vld_nxt;
    end
    fr_item_r <= fr_item_nxt;
  end

  assign push      = fr_vld_r;
  assign push_item = fr_item_r;
  assign front_vld = fr_vld_r;

endmodule

>>> rtl/bfe_queue.sv
// ---------------------------------------------------------------------------
// bfe_queue
// small register queue between the frame builder and the crc pipeline
// ---------------------------------------------------------------------------
module bfe_queue import bfe_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  bfe_item_t  push_item,
  input  logic       pop,
  output bfe_item_t  pop_item,
  output bfe_qstat_t q_stat
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  bfe_item_t       mem_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic            full, empty;
  logic            push_en, pop_en;

  assign full    = (cnt_r == CntW'(Depth));
  assign empty   = (cnt_r == '0);
  assign pop_en  = pop && !empty;
  assign push_en = push && (!full || pop_en);

  assign q_stat.valid = !empty;
  assign q_stat.ready = !full || pop_en;
  assign pop_item     = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push_en) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop_en) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push_en && !pop_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop_en && !push_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push_en) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> rtl/bfe_back.sv
// ---------------------------------------------------------------------------
// bfe_back
// crc-16 pipeline, one payload byte per stage, last stage drives the result
// ---------------------------------------------------------------------------
module bfe_back import bfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  bfe_qstat_t q_stat,
  input  bfe_item_t  pop_item,
  output logic       pop,
  output logic       res_valid,
  output bfe_item_t  res_item,
  output logic [15:0] res_crc
);

  localparam int LastStage = CRC_BYTES - 1;

  logic [CRC_BYTES-1:0] st_vld_r;
  logic [15:0]          st_crc_r  [CRC_BYTES];
  bfe_item_t            st_item_r [CRC_BYTES];

  // receiver never stalls, so the pipeline always drains the queue
  assign pop = q_stat.valid;

  for (genvar s = 0; s < CRC_BYTES; s++) begin : g_stage
    if (s == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_vld_r[s] <= 1'b0;
        end else begin
          st_vld_r[s] <= q_stat.valid;
        end
        st_item_r[s] <= pop_item;
        st_crc_r[s]  <= crc16_byte(CRC_INIT, pop_item.bytes[s]);
      end
    end else begin : g_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          st_vld_r[s] <= 1'b0;
        end else begin
          st_vld_r[s] <= st_vld_r[s-1];
        end
        st_item_r[s] <= st_item_r[s-1];
        st_crc_r[s]  <= crc16_byte(st_crc_r[s-1], st_item_r[s-1].bytes[s]);
      end
    end
  end

  assign res_valid = st_vld_r[LastStage];
  assign res_item  = st_item_r[LastStage];
  assign res_crc   = st_crc_r[LastStage];

endmodule

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the battery-monitor frame builder
// ---------------------------------------------------------------------------
// Sends frame requests on the start/busy handshake. An in-bench model builds
// the frame for each accepted request: identifier, payload bytes 0-5 and the
// crc-16 over bytes 0-3. The expected frame is queued. The result port is
// checked field by field against the oldest queued frame whenever out_valid
// is high. Directed tests cover every frame kind, field extremes, group wrap,
// temperature saturation and the unused command codes. A long random mix
// follows, with random gaps on the request side, and then a back-to-back run
// with no gaps.
// ---------------------------------------------------------------------------
module tb_top import bfe_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int          DRAIN_CYCLES = 20;

  localparam logic [2:0]  CMD_UNUSED_LO = 3'd6;
  localparam logic [2:0]  CMD_UNUSED_HI = 3'd7;

  localparam logic [16:0] MODULE_ID_BASE = 17'h06000;
  localparam logic [16:0] PACK1_ID       = 17'h08000;
  localparam logic [16:0] PACK2_ID       = 17'h08010;
  localparam logic [16:0] PACK3_ID       = 17'h08020;
  localparam logic [15:0] POLY           = 16'h1021;
  localparam logic [15:0] SEED           = 16'hFFFF;
  localparam logic [7:0]  PAD            = 8'hFF;
  localparam logic [7:0]  BALANCE_TYPE   = 8'h01;
  localparam logic [7:0]  VOLT_TYPE_BASE = 8'h02;
  localparam logic [7:0]  TEMP_TYPE_TOP  = 8'h0F;
  localparam logic [7:0]  CELLS_PER_ROW  = 8'd12;
  localparam int          TEMP_BIAS      = 40;
  localparam int          TEMP_CEIL      = 255;

  typedef struct packed {
    logic [2:0]       command;
    logic [7:0]       module_id;
    logic [7:0]       group;
    logic [5:0][15:0] value;
  } bms_request_t;

  typedef struct packed {
    logic [16:0]     frame_id;
    logic [5:0][7:0] payload;
    logic [7:0]      crc_high;
    logic [7:0]      crc_low;
  } bms_frame_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [2:0]  in_command;
  logic [7:0]  in_module_id;
  logic [7:0]  in_group;
  logic [15:0] in_value_0;
  logic [15:0] in_value_1;
  logic [15:0] in_value_2;
  logic [15:0] in_value_3;
  logic [15:0] in_value_4;
  logic [15:0] in_value_5;
  logic        out_valid;
  logic [16:0] out_frame_id;
  logic [7:0]  out_byte_0;
  logic [7:0]  out_byte_1;
  logic [7:0]  out_byte_2;
  logic [7:0]  out_byte_3;
  logic [7:0]  out_byte_4;
  logic [7:0]  out_byte_5;
  logic [7:0]  out_crc_high;
  logic [7:0]  out_crc_low;

  bms_frame_t  pending_frames[$];
  int unsigned mismatch_count;
  int unsigned cycle_count;

  battery_frame_encoder_crc16_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_command   (in_command),
    .in_module_id (in_module_id),
    .in_group     (in_group),
    .in_value_0   (in_value_0),
    .in_value_1   (in_value_1),
    .in_value_2   (in_value_2),
    .in_value_3   (in_value_3),
    .in_value_4   (in_value_4),
    .in_value_5   (in_value_5),
    .out_valid    (out_valid),
    .out_frame_id (out_frame_id),
    .out_byte_0   (out_byte_0),
    .out_byte_1   (out_byte_1),
    .out_byte_2   (out_byte_2),
    .out_byte_3   (out_byte_3),
    .out_byte_4   (out_byte_4),
    .out_byte_5   (out_byte_5),
    .out_crc_high (out_crc_high),
    .out_crc_low  (out_crc_low)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---- frame model ----

  function automatic logic [7:0] temp_byte(input logic [15:0] raw);
    int t;
    t = $signed(raw);
    t = t + TEMP_BIAS;
    if (t < 0) begin
      t = 0;
    end else if (t > TEMP_CEIL) begin
      t = TEMP_CEIL;
    end
    return t[7:0];
  endfunction

  function automatic logic [15:0] volt_bytes(input logic [15:0] raw);
    return {raw[7:0], 2'b00, raw[13:8]};
  endfunction

  function automatic logic [16:0] module_frame(input logic [7:0] module_id,
                                               input logic [7:0] kind);
    logic [7:0] m;
    m = module_id + 8'd1;
    return MODULE_ID_BASE + {1'b0, m, 8'h00} + {9'h000, kind};
  endfunction

  function automatic logic [15:0] head_crc(input logic [5:0][7:0] payload);
    logic [15:0] c;
    c = SEED;
    for (int i = 0; i < 4; i++) begin
      c = c ^ {payload[i], 8'h00};
      for (int k = 0; k < 8; k++) begin
        c = c[15] ? ({c[14:0], 1'b0} ^ POLY) : {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  // returns 0 for command codes that build no frame
  function automatic bit build_frame(input bms_request_t req, output bms_frame_t frm);
    logic [7:0]  kind;
    logic [15:0] crc;
    frm = '0;
    case (req.command)
      CMD_BALANCE: begin
        frm.frame_id = module_frame(req.module_id, BALANCE_TYPE);
        frm.payload[0] = PAD;
        frm.payload[1] = PAD;
        {frm.payload[2], frm.payload[3]} = req.value[0];
        {frm.payload[4], frm.payload[5]} = req.value[1];
      end
      CMD_CELL_VOLTS: begin
        kind = ((req.group / CELLS_PER_ROW) << 4) + VOLT_TYPE_BASE
               + (req.group % CELLS_PER_ROW);
        frm.frame_id = module_frame(req.module_id, kind);
        for (int i = 0; i < 3; i++) begin
          {frm.payload[2*i], frm.payload[2*i+1]} = volt_bytes(req.value[i]);
        end
      end
      CMD_TEMPS: begin
        kind = TEMP_TYPE_TOP - req.group;
        frm.frame_id = module_frame(req.module_id, kind);
        for (int i = 0; i < 6; i++) begin
          frm.payload[i] = temp_byte(req.value[i]);
        end
      end
      CMD_PACK1: begin
        frm.frame_id = PACK1_ID;
        {frm.payload[0], frm.payload[1]} = req.value[0];
        {frm.payload[2], frm.payload[3]} = volt_bytes(req.value[1]);
        {frm.payload[4], frm.payload[5]} = volt_bytes(req.value[2]);
      end
      CMD_PACK2: begin
        frm.frame_id = PACK2_ID;
        {frm.payload[0], frm.payload[1]} = volt_bytes(req.value[0]);
        {frm.payload[2], frm.payload[3]} = req.value[1];
        {frm.payload[4], frm.payload[5]} = req.value[2];
      end
      CMD_PACK3: begin
        frm.frame_id = PACK3_ID;
        for (int i = 0; i < 3; i++) begin
          frm.payload[i] = temp_byte(req.value[i]);
        end
        frm.payload[3] = PAD;
        frm.payload[4] = PAD;
        frm.payload[5] = PAD;
      end
      default: begin
        return 1'b0;
      end
    endcase
    crc = head_crc(frm.payload);
    frm.crc_high = crc[15:8];
    frm.crc_low = crc[7:0];
    return 1'b1;
  endfunction

  // ---- result checking ----

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want, cycle_count);
    mismatch_count++;
  endtask

  task automatic check_field(input string what, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_mismatch(what, got, want);
    end
  endtask

  always @(posedge clk) begin
    bms_frame_t want;
    if (rst_n && out_valid) begin
      if (pending_frames.size() == 0) begin
        report_mismatch("unexpected frame id", out_frame_id, 0);
      end else begin
        want = pending_frames.pop_front();
        check_field("frame_id", out_frame_id, want.frame_id);
        check_field("byte_0", out_byte_0, want.payload[0]);
        check_field("byte_1", out_byte_1, want.payload[1]);
        check_field("byte_2", out_byte_2, want.payload[2]);
        check_field("byte_3", out_byte_3, want.payload[3]);
        check_field("byte_4", out_byte_4, want.payload[4]);
        check_field("byte_5", out_byte_5, want.payload[5]);
        check_field("crc_high", out_crc_high, want.crc_high);
        check_field("crc_low", out_crc_low, want.crc_low);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---- request side ----

  // busy only moves on the rising edge, so it is read at the falling edge
  task automatic send_request(input bms_request_t req);
    bms_frame_t frm;
    @(negedge clk);
    start        <= 1'b1;
    in_command   <= req.command;
    in_module_id <= req.module_id;
    in_group     <= req.group;
    in_value_0   <= req.value[0];
    in_value_1   <= req.value[1];
    in_value_2   <= req.value[2];
    in_value_3   <= req.value[3];
    in_value_4   <= req.value[4];
    in_value_5   <= req.value[5];
    while (busy) begin
      @(negedge clk);
    end
    @(posedge clk);
    if (build_frame(req, frm)) begin
      pending_frames.push_back(frm);
    end
  endtask

  // start low, with junk on the command, module id and first value ports
  task automatic hold_off(input int cycles);
    repeat (cycles) begin
      @(negedge clk);
      start        <= 1'b0;
      in_command   <= 3'($urandom);
      in_module_id <= 8'($urandom);
      in_value_0   <= 16'($urandom);
    end
  endtask

  function automatic logic [15:0] random_value();
    case ($urandom_range(3))
      0: return 16'($urandom_range(300)) - 16'd60;
      1: return {$urandom_range(1) ? 8'hFF : 8'h00, 8'($urandom)};
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic bms_request_t random_request();
    bms_request_t req;
    if ($urandom_range(9) == 0) begin
      req.command = $urandom_range(1) ? CMD_UNUSED_LO : CMD_UNUSED_HI;
    end else begin
      req.command = 3'($urandom_range(CMD_PACK3));
    end
    req.module_id = 8'($urandom);
    req.group = $urandom_range(3) == 0 ? 8'($urandom) : 8'($urandom_range(24));
    for (int i = 0; i < 6; i++) begin
      req.value[i] = random_value();
    end
    return req;
  endfunction

  function automatic bms_request_t make_request(input logic [2:0] command,
                                                input logic [7:0] module_id,
                                                input logic [7:0] group,
                                                input logic [15:0] v0, input logic [15:0] v1,
                                                input logic [15:0] v2, input logic [15:0] v3,
                                                input logic [15:0] v4, input logic [15:0] v5);
    bms_request_t req;
    req.command = command;
    req.module_id = module_id;
    req.group = group;
    req.value = {v5, v4, v3, v2, v1, v0};
    return req;
  endfunction

  // ---- tests ----

  task automatic test_balance();
    send_request(make_request(CMD_BALANCE, 8'h00, 8'h00, 16'h0000, 16'h0000,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(CMD_BALANCE, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                              16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(CMD_BALANCE, 8'h7F, 8'h5A, 16'h8001, 16'h1234,
                              16'hA5A5, 16'h5A5A, 16'h0F0F, 16'hF0F0));
  endtask

  task automatic test_cell_volts();
    send_request(make_request(CMD_CELL_VOLTS, 8'h00, 8'd0, 16'hFFFF, 16'h3FFF,
                              16'hC000, 16'h1111, 16'h2222, 16'h3333));
    send_request(make_request(CMD_CELL_VOLTS, 8'h10, 8'd11, 16'h0000, 16'h4000,
                              16'h8123, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(CMD_CELL_VOLTS, 8'hFE, 8'd12, 16'h3F00, 16'h00FF,
                              16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(CMD_CELL_VOLTS, 8'hFF, 8'd255, 16'h1234, 16'hABCD,
                              16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_temps();
    send_request(make_request(CMD_TEMPS, 8'h00, 8'd0, 16'h7FFF, 16'h8000,
                              16'hFFD8, 16'hFFD7, 16'd215, 16'd216));
    send_request(make_request(CMD_TEMPS, 8'hFF, 8'd15, 16'h0000, 16'hFFFF,
                              16'd214, 16'hFFD9, 16'h0100, 16'hFF00));
    send_request(make_request(CMD_TEMPS, 8'h42, 8'd16, 16'd25, 16'hFFF6,
                              16'h4000, 16'hC000, 16'd1, 16'hFFFE));
    send_request(make_request(CMD_TEMPS, 8'h80, 8'd255, 16'hFFFF, 16'h7FFF,
                              16'h8000, 16'h0000, 16'hFFD8, 16'd215));
  endtask

  task automatic test_pack_frames();
    send_request(make_request(CMD_PACK1, 8'h00, 8'h00, 16'hFFFF, 16'hFFFF,
                              16'hC000, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(CMD_PACK1, 8'hFF, 8'hFF, 16'h0000, 16'h3FFF,
                              16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(CMD_PACK2, 8'h00, 8'h00, 16'hFFFF, 16'h0000,
                              16'hFFFF, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(CMD_PACK2, 8'hFF, 8'hFF, 16'h4000, 16'hFFFF,
                              16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(CMD_PACK3, 8'h00, 8'h00, 16'h7FFF, 16'h8000,
                              16'hFFD8, 16'h0000, 16'h0000, 16'h0000));
    send_request(make_request(CMD_PACK3, 8'hFF, 8'hFF, 16'd215, 16'd216,
                              16'hFFD7, 16'hFFFF, 16'hFFFF, 16'hFFFF));
  endtask

  task automatic test_unused_commands();
    send_request(make_request(CMD_UNUSED_LO, 8'h12, 8'h34, 16'h1111, 16'h2222,
                              16'h3333, 16'h4444, 16'h5555, 16'h6666));
    send_request(make_request(CMD_UNUSED_HI, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_request(make_request(CMD_BALANCE, 8'h01, 8'h00, 16'hBEEF, 16'hCAFE,
                              16'h0000, 16'h0000, 16'h0000, 16'h0000));
  endtask

  task automatic test_random_with_gaps(input int count);
    int run_left;
    run_left = 0;
    for (int n = 0; n < count; n++) begin
      if (run_left > 0) begin
        run_left--;
      end else if ($urandom_range(9) == 0) begin
        run_left = $urandom_range(5, 20);
      end else if ($urandom_range(2) == 0) begin
        hold_off($urandom_range(1, 12));
      end
      send_request(random_request());
    end
  endtask

  task automatic test_back_to_back(input int count);
    repeat (count) begin
      send_request(random_request());
    end
  endtask

  task automatic drain_and_finish();
    hold_off(1);
    while (pending_frames.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = '0;
    in_module_id   = '0;
    in_group       = '0;
    in_value_0     = '0;
    in_value_1     = '0;
    in_value_2     = '0;
    in_value_3     = '0;
    in_value_4     = '0;
    in_value_5     = '0;
    mismatch_count = 0;
    cycle_count    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_balance();
    test_cell_volts();
    hold_off(3);
    test_temps();
    test_pack_frames();
    test_unused_commands();
    test_random_with_gaps(300);
    test_back_to_back(100);
    drain_and_finish();
  end

endmodule
